// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the pick and place sequencer
// Holds the state codes, command codes, register addresses and the item
// structs that pass between the sequencer's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

   // Largest number of moves in one plan.
   localparam int MAX_MOVES = 16;

   // Milliseconds per second, used by the timed waits.
   localparam int MS_PER_S = 1000;

   // Width of the elapsed-time product: 32-bit tick span times 1000.
   localparam int SPAN_W = 42;

   // Execution states.
   localparam logic [3:0] ST_IDLE          = 4'd0;
   localparam logic [3:0] ST_WAIT_ROUTE    = 4'd1;
   localparam logic [3:0] ST_APPROACH      = 4'd2;
   localparam logic [3:0] ST_LOWER_PICK    = 4'd3;
   localparam logic [3:0] ST_GRIP_DWELL    = 4'd4;
   localparam logic [3:0] ST_RAISE_PICK    = 4'd5;
   localparam logic [3:0] ST_TRANSFER      = 4'd6;
   localparam logic [3:0] ST_LOWER_PLACE   = 4'd7;
   localparam logic [3:0] ST_RELEASE_DWELL = 4'd8;
   localparam logic [3:0] ST_RAISE_PLACE   = 4'd9;
   localparam logic [3:0] ST_COMPLETE      = 4'd10;
   localparam logic [3:0] ST_ERROR         = 4'd11;

   // Item function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_POLL  = 1'b1;

   // Route result codes.
   localparam logic [3:0] ROUTE_OK      = 4'd0;
   localparam logic [3:0] ROUTE_NO_CODE = 4'd15;

   // Solver result code for a good plan.
   localparam logic [3:0] SOLVER_OK = 4'd0;

   // Route phase codes.
   localparam logic PHASE_APPROACH = 1'b0;
   localparam logic PHASE_TRANSFER = 1'b1;

   // Gripper command codes.
   localparam logic [1:0] GRIP_NONE  = 2'd0;
   localparam logic [1:0] GRIP_CLOSE = 2'd1;
   localparam logic [1:0] GRIP_OPEN  = 2'd2;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_LIFT_TRAVEL   = 2'd0;
   localparam logic [1:0] REG_GRIP_DWELL    = 2'd1;
   localparam logic [1:0] REG_RELEASE_DWELL = 2'd2;
   localparam logic [1:0] REG_TICK_FREQ     = 2'd3;

   // Register reset values.
   localparam logic [15:0] LIFT_TRAVEL_RST   = 16'd350;
   localparam logic [15:0] GRIP_DWELL_RST    = 16'd300;
   localparam logic [15:0] RELEASE_DWELL_RST = 16'd200;
   localparam logic [19:0] TICK_FREQ_RST     = 20'd1000;

   // Configuration seen by the step logic.
   typedef struct packed {
      logic [15:0] lift_time;
      logic [15:0] grip_hold;
      logic [15:0] drop_hold;
      logic [19:0] tick_freq_hz;
   } pps_cfg_type;

   // One input item.
   typedef struct packed {
      logic        func;
      logic [3:0]  solver_result;
      logic [4:0]  plan_moves;
      logic        submit_ok;
      logic [31:0] tick_stamp;
      logic [31:0] route_id;
      logic [3:0]  route_result;
      logic        route_active;
      logic        route_phase;
      logic        route_complete;
      logic        crane_ok;
   } pps_req_type;

   // One result item.
   typedef struct packed {
      logic [3:0]  exec_state;
      logic [3:0]  decision_result;
      logic [3:0]  last_route_result;
      logic [4:0]  active_move;
      logic [31:0] active_plan_id;
      logic        cmd_submit;
      logic        cmd_cancel;
      logic [1:0]  cmd_grip;
      logic        cmd_raise;
      logic        cmd_resume;
      logic        published;
   } pps_rsp_type;

endpackage

`default_nettype wire

// ===== src/pps_core.sv =====
// ----------------------------------------------------------------------------
// pps_core: sequencer state and step logic
// Holds the sequencer state and works out, for one input item, the next
// state and the result item in a single combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_core
   import pps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  pps_req_type req,
   input  pps_cfg_type cfg,
   output pps_rsp_type rsp
);

   // Sequencer state.
   logic [3:0]  phase_ff, phase_in;
   logic        running_ff, running_in;
   logic [4:0]  move_index_ff, move_index_in;
   logic [4:0]  moves_total_ff, moves_total_in;
   logic [31:0] plan_id_ff, plan_id_in;
   logic [31:0] next_id_ff, next_id_in;
   logic [31:0] mark_tick_ff, mark_tick_in;
   logic [3:0]  route_code_ff, route_code_in;
   logic [3:0]  solver_code_ff, solver_code_in;

   logic [15:0]       limit;
   logic [31:0]       tick_span;
   logic [SPAN_W-1:0] span_ms;
   logic [SPAN_W-1:0] need_ms;
   logic              passed;
   logic [31:0]       id_bump;
   logic [4:0]        moves_sat;
   logic [4:0]        move_next;

   // Pick the limit that belongs to the current timed wait.
   always_comb begin
      case (phase_ff)
         ST_GRIP_DWELL:    limit = cfg.grip_hold;
         ST_RELEASE_DWELL: limit = cfg.drop_hold;
         default:          limit = cfg.lift_time;
      endcase
   end

   // Elapsed-time test: span * 1000 >= limit * tick rate; a zero rate
   // stops the clock, so only a zero limit passes.
   assign tick_span = req.tick_stamp - mark_tick_ff;
   assign span_ms   = SPAN_W'(tick_span) * SPAN_W'(MS_PER_S);
   assign need_ms   = SPAN_W'(limit) * SPAN_W'(cfg.tick_freq_hz);
   assign passed    = (cfg.tick_freq_hz == 20'd0) ? (limit == 16'd0)
                                                  : (span_ms >= need_ms);

   // Plan id counter skips zero when it wraps.
   assign id_bump = (next_id_ff == 32'hFFFF_FFFF) ? 32'd1 : next_id_ff + 32'd1;

   assign moves_sat = (req.plan_moves > 5'(MAX_MOVES)) ? 5'(MAX_MOVES)
                                                       : req.plan_moves;
   assign move_next = move_index_ff + 5'd1;

   // Step logic for one item.
   always_comb begin
      phase_in       = phase_ff;
      running_in     = running_ff;
      move_index_in  = move_index_ff;
      moves_total_in = moves_total_ff;
      plan_id_in     = plan_id_ff;
      next_id_in     = next_id_ff;
      mark_tick_in   = mark_tick_ff;
      route_code_in  = route_code_ff;
      solver_code_in = solver_code_ff;
      rsp            = '0;

      if (req.func == FUNC_START) begin
         // A start item cancels the route layer and opens a new plan, or goes to error.
         rsp.cmd_cancel = 1'b1;
         rsp.published  = 1'b1;
         solver_code_in = req.solver_result;
         moves_total_in = moves_sat;
         move_index_in  = 5'd0;
         plan_id_in     = 32'd0;
         route_code_in  = ROUTE_NO_CODE;
         if (req.solver_result == SOLVER_OK && moves_sat != 5'd0) begin
            next_id_in     = id_bump;
            rsp.cmd_submit = 1'b1;
            if (req.submit_ok) begin
               plan_id_in = next_id_ff;
               phase_in   = ST_WAIT_ROUTE;
               running_in = 1'b1;
            end else begin
               phase_in   = ST_ERROR;
               running_in = 1'b0;
            end
         end else begin
            phase_in   = ST_ERROR;
            running_in = 1'b0;
         end
      end else if (running_ff && req.route_id == plan_id_ff) begin
         route_code_in = req.route_result;
         if (req.route_result != ROUTE_OK) begin
            // A bad route result ends the plan.
            phase_in       = ST_ERROR;
            running_in     = 1'b0;
            rsp.cmd_cancel = 1'b1;
            rsp.published  = 1'b1;
         end else begin
            case (phase_ff)
               ST_WAIT_ROUTE: begin
                  if (req.route_active) begin
                     phase_in      = ST_APPROACH;
                     rsp.published = 1'b1;
                  end
               end
               ST_APPROACH: begin
                  if (req.route_phase == PHASE_APPROACH && req.route_complete) begin
                     phase_in      = ST_LOWER_PICK;
                     mark_tick_in  = req.tick_stamp;
                     rsp.published = 1'b1;
                  end
               end
               ST_LOWER_PICK, ST_LOWER_PLACE: begin
                  if (passed) begin
                     rsp.cmd_grip  = (phase_ff == ST_LOWER_PICK) ? GRIP_CLOSE
                                                                 : GRIP_OPEN;
                     rsp.published = 1'b1;
                     if (req.crane_ok) begin
                        phase_in     = (phase_ff == ST_LOWER_PICK) ? ST_GRIP_DWELL
                                                                   : ST_RELEASE_DWELL;
                        mark_tick_in = req.tick_stamp;
                     end else begin
                        phase_in   = ST_ERROR;
                        running_in = 1'b0;
                     end
                  end
               end
               ST_GRIP_DWELL, ST_RELEASE_DWELL: begin
                  if (passed) begin
                     rsp.cmd_raise = 1'b1;
                     rsp.published = 1'b1;
                     if (req.crane_ok) begin
                        phase_in     = (phase_ff == ST_GRIP_DWELL) ? ST_RAISE_PICK
                                                                   : ST_RAISE_PLACE;
                        mark_tick_in = req.tick_stamp;
                     end else begin
                        phase_in   = ST_ERROR;
                        running_in = 1'b0;
                     end
                  end
               end
               ST_RAISE_PICK: begin
                  if (passed) begin
                     rsp.cmd_resume = 1'b1;
                     phase_in       = ST_TRANSFER;
                     rsp.published  = 1'b1;
                  end
               end
               ST_TRANSFER: begin
                  if (req.route_phase == PHASE_TRANSFER && req.route_complete &&
                      !req.route_active) begin
                     phase_in      = ST_LOWER_PLACE;
                     mark_tick_in  = req.tick_stamp;
                     rsp.published = 1'b1;
                  end
               end
               ST_RAISE_PLACE: begin
                  if (passed) begin
                     rsp.published = 1'b1;
                     move_index_in = move_next;
                     if (move_next >= moves_total_ff) begin
                        phase_in   = ST_COMPLETE;
                        running_in = 1'b0;
                     end else begin
                        // Submit the next move under a fresh plan id.
                        next_id_in     = id_bump;
                        rsp.cmd_submit = 1'b1;
                        if (req.submit_ok) begin
                           plan_id_in    = next_id_ff;
                           phase_in      = ST_WAIT_ROUTE;
                           route_code_in = ROUTE_OK;
                        end else begin
                           phase_in   = ST_ERROR;
                           running_in = 1'b0;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // The status fields show the state after the step.
      rsp.exec_state        = phase_in;
      rsp.decision_result   = solver_code_in;
      rsp.last_route_result = route_code_in;
      rsp.active_move       = move_index_in;
      rsp.active_plan_id    = plan_id_in;
   end

   // State update on each processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ST_IDLE;
         running_ff     <= 1'b0;
         move_index_ff  <= 5'd0;
         moves_total_ff <= 5'd0;
         plan_id_ff     <= 32'd0;
         next_id_ff     <= 32'd1;
         mark_tick_ff   <= 32'd0;
         route_code_ff  <= ROUTE_NO_CODE;
         solver_code_ff <= SOLVER_OK;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         running_ff     <= running_in;
         move_index_ff  <= move_index_in;
         moves_total_ff <= moves_total_in;
         plan_id_ff     <= plan_id_in;
         next_id_ff     <= next_id_in;
         mark_tick_ff   <= mark_tick_in;
         route_code_ff  <= route_code_in;
         solver_code_ff <= solver_code_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pick_place_sequencer.sv =====
// Path: an accepted item waits in the input register and is stepped from
// there into the result register once the result register is free; its
// result is offered on the output channel from the result register.
// Throughput: one item per cycle; a stalled result holds the input register.
// Reset: synchronous, active high; returns to idle with the state and
// configuration registers at their reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
// pick_place_sequencer: crane move sequencer, top level
// Input item register, configuration registers on an APB-style port, the
// step core, and a result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pick_place_sequencer
   import pps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // Input item channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_solver_result,
   input  logic [4:0]  req_plan_moves,
   input  logic        req_submit_ok,
   input  logic [31:0] req_tick_stamp,
   input  logic [31:0] req_route_id,
   input  logic [3:0]  req_route_result,
   input  logic        req_route_active,
   input  logic        req_route_phase,
   input  logic        req_route_complete,
   input  logic        req_crane_ok,

   // Result item channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_exec_state,
   output logic [3:0]  rsp_decision_result,
   output logic [3:0]  rsp_last_route_result,
   output logic [4:0]  rsp_active_move,
   output logic [31:0] rsp_active_plan_id,
   output logic        rsp_cmd_submit,
   output logic        rsp_cmd_cancel,
   output logic [1:0]  rsp_cmd_grip,
   output logic        rsp_cmd_raise,
   output logic        rsp_cmd_resume,
   output logic        rsp_published,

   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pps_cfg_type cfg_ff;
   pps_req_type req_ff;
   logic        in_valid_ff;
   pps_rsp_type rsp_ff;
   logic        out_valid_ff;
   pps_rsp_type step_rsp;
   logic        out_free;
   logic        advance;
   logic        csr_write;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lift_time    <= LIFT_TRAVEL_RST;
         cfg_ff.grip_hold    <= GRIP_DWELL_RST;
         cfg_ff.drop_hold    <= RELEASE_DWELL_RST;
         cfg_ff.tick_freq_hz <= TICK_FREQ_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_LIFT_TRAVEL:   cfg_ff.lift_time    <= csr_pwdata[15:0];
            REG_GRIP_DWELL:    cfg_ff.grip_hold    <= csr_pwdata[15:0];
            REG_RELEASE_DWELL: cfg_ff.drop_hold    <= csr_pwdata[15:0];
            REG_TICK_FREQ:     cfg_ff.tick_freq_hz <= csr_pwdata[19:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[3:2])
         REG_LIFT_TRAVEL:   csr_prdata = {16'd0, cfg_ff.lift_time};
         REG_GRIP_DWELL:    csr_prdata = {16'd0, cfg_ff.grip_hold};
         REG_RELEASE_DWELL: csr_prdata = {16'd0, cfg_ff.drop_hold};
         REG_TICK_FREQ:     csr_prdata = {12'd0, cfg_ff.tick_freq_hz};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Flow control: the held item steps when the result register is free.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input item register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff.func           <= req_func;
         req_ff.solver_result  <= req_solver_result;
         req_ff.plan_moves     <= req_plan_moves;
         req_ff.submit_ok      <= req_submit_ok;
         req_ff.tick_stamp     <= req_tick_stamp;
         req_ff.route_id       <= req_route_id;
         req_ff.route_result   <= req_route_result;
         req_ff.route_active   <= req_route_active;
         req_ff.route_phase    <= req_route_phase;
         req_ff.route_complete <= req_route_complete;
         req_ff.crane_ok       <= req_crane_ok;
      end
   end

   // Step logic and sequencer state.
   pps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .rsp     (step_rsp)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_exec_state        = rsp_ff.exec_state;
   assign rsp_decision_result   = rsp_ff.decision_result;
   assign rsp_last_route_result = rsp_ff.last_route_result;
   assign rsp_active_move       = rsp_ff.active_move;
   assign rsp_active_plan_id    = rsp_ff.active_plan_id;
   assign rsp_cmd_submit        = rsp_ff.cmd_submit;
   assign rsp_cmd_cancel        = rsp_ff.cmd_cancel;
   assign rsp_cmd_grip          = rsp_ff.cmd_grip;
   assign rsp_cmd_raise         = rsp_ff.cmd_raise;
   assign rsp_cmd_resume        = rsp_ff.cmd_resume;
   assign rsp_published         = rsp_ff.published;

endmodule

`default_nettype wire

// ===== src/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker: port-level checks for the pick and place sequencer
// Watches the result channel and checks how commands and states relate.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_checker
   import pps_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_exec_state,
   input logic        rsp_cmd_submit,
   input logic        rsp_cmd_cancel,
   input logic [1:0]  rsp_cmd_grip,
   input logic        rsp_published
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_exec_state))
      else $error("stalled result item changed");

   // A submission leaves the sequencer waiting for the route or in error.
   a_submit_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_submit |->
         rsp_exec_state == ST_WAIT_ROUTE || rsp_exec_state == ST_ERROR)
      else $error("submit strobe in unexpected state");

   // A cancel comes only with a start item or a failed route.
   a_cancel_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_cancel |->
         rsp_published &&
         (rsp_exec_state == ST_WAIT_ROUTE || rsp_exec_state == ST_ERROR))
      else $error("cancel strobe in unexpected state");

   // While idle no command is given and nothing is republished.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exec_state == ST_IDLE |->
         !rsp_published && !rsp_cmd_submit && !rsp_cmd_cancel &&
         rsp_cmd_grip == GRIP_NONE)
      else $error("activity reported while idle");

endmodule

bind pick_place_sequencer pps_checker u_pps_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_exec_state (rsp_exec_state),
   .rsp_cmd_submit (rsp_cmd_submit),
   .rsp_cmd_cancel (rsp_cmd_cancel),
   .rsp_cmd_grip   (rsp_cmd_grip),
   .rsp_published  (rsp_published)
);

`default_nettype wire

// ===== tb/sv/pick_place_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pick_place_sequencer_tb: self-checking bench for the crane move sequencer
// Walks solved plans through every move phase with mostly well-formed poll
// items, mixed with noise, route errors and crane refusals, under several
// register settings. A scoreboard class predicts every status item and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

module pick_place_sequencer_tb;
   import pps_pkg::*;

   localparam int        IDLE_LIMIT = 5000;
   localparam int        SEG_ITEMS  = 185;
   localparam int        REQ_W      = $bits(pps_req_type);
   localparam logic [4:0] MOVE_CAP  = 5'(MAX_MOVES);

   // Predicts the status item for each accepted input item and holds the
   // predictions until the block returns them.
   class crane_status_board;
      logic [15:0] lift_ms;
      logic [15:0] grip_ms;
      logic [15:0] release_ms;
      logic [19:0] freq_hz;
      logic [3:0]  phase;
      bit          running;
      logic [4:0]  move_idx;
      logic [4:0]  moves_total;
      logic [31:0] plan_id;
      logic [31:0] next_id;
      logic [31:0] mark_tick;
      logic [3:0]  route_code;
      logic [3:0]  solver_code;
      pps_rsp_type status_queue[$];
      int          mismatches;

      function new();
         lift_ms     = LIFT_TRAVEL_RST;
         grip_ms     = GRIP_DWELL_RST;
         release_ms  = RELEASE_DWELL_RST;
         freq_hz     = TICK_FREQ_RST;
         phase       = ST_IDLE;
         running     = 1'b0;
         move_idx    = '0;
         moves_total = '0;
         plan_id     = '0;
         next_id     = 32'd1;
         mark_tick   = '0;
         route_code  = ROUTE_NO_CODE;
         solver_code = SOLVER_OK;
         mismatches  = 0;
      endfunction

      function void load_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_LIFT_TRAVEL:   lift_ms    = value[15:0];
            REG_GRIP_DWELL:    grip_ms    = value[15:0];
            REG_RELEASE_DWELL: release_ms = value[15:0];
            REG_TICK_FREQ:     freq_hz    = value[19:0];
            default: ;
         endcase
      endfunction

      // Plan ids count up and never take the value zero.
      function logic [31:0] take_id();
         logic [31:0] id;
         id = next_id;
         next_id = next_id + 32'd1;
         if (next_id == 32'd0) begin
            next_id = 32'd1;
         end
         return id;
      endfunction

      // Elapsed milliseconds reach the limit when span*1000 >= limit*rate.
      function bit elapsed(logic [31:0] now, logic [15:0] limit);
         logic [31:0] diff;
         logic [63:0] span;
         logic [63:0] bound;
         if (freq_hz == 20'd0) begin
            return limit == 16'd0;
         end
         diff  = now - mark_tick;
         span  = {32'd0, diff} * 64'd1000;
         bound = {48'd0, limit} * {44'd0, freq_hz};
         return span >= bound;
      endfunction

      function void stop_run();
         phase   = ST_ERROR;
         running = 1'b0;
      endfunction

      // Timed phase that finished: command given, crane answer decides.
      function void timed_command(bit crane_ok, logic [3:0] next_phase, logic [31:0] now);
         if (crane_ok) begin
            phase     = next_phase;
            mark_tick = now;
         end else begin
            stop_run();
         end
      endfunction

      function void note_item(pps_req_type r);
         pps_rsp_type e;
         logic [31:0] id;
         e = '0;
         if (r.func == FUNC_START) begin
            e.cmd_cancel = 1'b1;
            e.published  = 1'b1;
            solver_code  = r.solver_result;
            moves_total  = (r.plan_moves > MOVE_CAP) ? MOVE_CAP : r.plan_moves;
            move_idx     = '0;
            plan_id      = '0;
            route_code   = ROUTE_NO_CODE;
            if (r.solver_result == SOLVER_OK && moves_total != 5'd0) begin
               id = take_id();
               e.cmd_submit = 1'b1;
               if (r.submit_ok) begin
                  plan_id = id;
                  phase   = ST_WAIT_ROUTE;
                  running = 1'b1;
               end else begin
                  stop_run();
               end
            end else begin
               stop_run();
            end
         end else if (running && r.route_id == plan_id) begin
            route_code = r.route_result;
            if (r.route_result != ROUTE_OK) begin
               stop_run();
               e.cmd_cancel = 1'b1;
               e.published  = 1'b1;
            end else begin
               case (phase)
                  ST_WAIT_ROUTE: begin
                     if (r.route_active) begin
                        phase = ST_APPROACH;
                        e.published = 1'b1;
                     end
                  end
                  ST_APPROACH: begin
                     if (r.route_phase == PHASE_APPROACH && r.route_complete) begin
                        phase      = ST_LOWER_PICK;
                        mark_tick  = r.tick_stamp;
                        e.published = 1'b1;
                     end
                  end
                  ST_LOWER_PICK: begin
                     if (elapsed(r.tick_stamp, lift_ms)) begin
                        e.cmd_grip  = GRIP_CLOSE;
                        e.published = 1'b1;
                        timed_command(r.crane_ok, ST_GRIP_DWELL, r.tick_stamp);
                     end
                  end
                  ST_GRIP_DWELL: begin
                     if (elapsed(r.tick_stamp, grip_ms)) begin
                        e.cmd_raise = 1'b1;
                        e.published = 1'b1;
                        timed_command(r.crane_ok, ST_RAISE_PICK, r.tick_stamp);
                     end
                  end
                  ST_RAISE_PICK: begin
                     if (elapsed(r.tick_stamp, lift_ms)) begin
                        e.cmd_resume = 1'b1;
                        e.published  = 1'b1;
                        phase = ST_TRANSFER;
                     end
                  end
                  ST_TRANSFER: begin
                     if (r.route_phase == PHASE_TRANSFER && r.route_complete &&
                         !r.route_active) begin
                        phase      = ST_LOWER_PLACE;
                        mark_tick  = r.tick_stamp;
                        e.published = 1'b1;
                     end
                  end
                  ST_LOWER_PLACE: begin
                     if (elapsed(r.tick_stamp, lift_ms)) begin
                        e.cmd_grip  = GRIP_OPEN;
                        e.published = 1'b1;
                        timed_command(r.crane_ok, ST_RELEASE_DWELL, r.tick_stamp);
                     end
                  end
                  ST_RELEASE_DWELL: begin
                     if (elapsed(r.tick_stamp, release_ms)) begin
                        e.cmd_raise = 1'b1;
                        e.published = 1'b1;
                        timed_command(r.crane_ok, ST_RAISE_PLACE, r.tick_stamp);
                     end
                  end
                  ST_RAISE_PLACE: begin
                     if (elapsed(r.tick_stamp, lift_ms)) begin
                        e.published = 1'b1;
                        move_idx = move_idx + 5'd1;
                        if (move_idx >= moves_total) begin
                           phase   = ST_COMPLETE;
                           running = 1'b0;
                        end else begin
                           id = take_id();
                           e.cmd_submit = 1'b1;
                           if (r.submit_ok) begin
                              plan_id    = id;
                              phase      = ST_WAIT_ROUTE;
                              route_code = ROUTE_OK;
                           end else begin
                              stop_run();
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         e.exec_state        = phase;
         e.decision_result   = solver_code;
         e.last_route_result = route_code;
         e.active_move       = move_idx;
         e.active_plan_id    = plan_id;
         status_queue.push_back(e);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_status(pps_rsp_type a);
         pps_rsp_type e;
         if (status_queue.size() == 0) begin
            mismatches++;
            $display("%0t: status item with no prediction, state %0d", $time, a.exec_state);
            return;
         end
         e = status_queue.pop_front();
         check_field("exec_state", 32'(e.exec_state), 32'(a.exec_state));
         check_field("decision_result", 32'(e.decision_result), 32'(a.decision_result));
         check_field("last_route_result", 32'(e.last_route_result),
                     32'(a.last_route_result));
         check_field("active_move", 32'(e.active_move), 32'(a.active_move));
         check_field("active_plan_id", e.active_plan_id, a.active_plan_id);
         check_field("cmd_submit", 32'(e.cmd_submit), 32'(a.cmd_submit));
         check_field("cmd_cancel", 32'(e.cmd_cancel), 32'(a.cmd_cancel));
         check_field("cmd_grip", 32'(e.cmd_grip), 32'(a.cmd_grip));
         check_field("cmd_raise", 32'(e.cmd_raise), 32'(a.cmd_raise));
         check_field("cmd_resume", 32'(e.cmd_resume), 32'(a.cmd_resume));
         check_field("published", 32'(e.published), 32'(a.published));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [3:0]  req_solver_result;
   logic [4:0]  req_plan_moves;
   logic        req_submit_ok;
   logic [31:0] req_tick_stamp;
   logic [31:0] req_route_id;
   logic [3:0]  req_route_result;
   logic        req_route_active;
   logic        req_route_phase;
   logic        req_route_complete;
   logic        req_crane_ok;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_exec_state;
   logic [3:0]  rsp_decision_result;
   logic [3:0]  rsp_last_route_result;
   logic [4:0]  rsp_active_move;
   logic [31:0] rsp_active_plan_id;
   logic        rsp_cmd_submit;
   logic        rsp_cmd_cancel;
   logic [1:0]  rsp_cmd_grip;
   logic        rsp_cmd_raise;
   logic        rsp_cmd_resume;
   logic        rsp_published;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   crane_status_board sb;
   bit          calm;
   int          idle_cycles;

   pick_place_sequencer DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_solver_result     (req_solver_result),
      .req_plan_moves        (req_plan_moves),
      .req_submit_ok         (req_submit_ok),
      .req_tick_stamp        (req_tick_stamp),
      .req_route_id          (req_route_id),
      .req_route_result      (req_route_result),
      .req_route_active      (req_route_active),
      .req_route_phase       (req_route_phase),
      .req_route_complete    (req_route_complete),
      .req_crane_ok          (req_crane_ok),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_exec_state        (rsp_exec_state),
      .rsp_decision_result   (rsp_decision_result),
      .rsp_last_route_result (rsp_last_route_result),
      .rsp_active_move       (rsp_active_move),
      .rsp_active_plan_id    (rsp_active_plan_id),
      .rsp_cmd_submit        (rsp_cmd_submit),
      .rsp_cmd_cancel        (rsp_cmd_cancel),
      .rsp_cmd_grip          (rsp_cmd_grip),
      .rsp_cmd_raise         (rsp_cmd_raise),
      .rsp_cmd_resume        (rsp_cmd_resume),
      .rsp_published         (rsp_published),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle lengths: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 70) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Smallest tick span that passes a limit at the current tick rate.
   function automatic logic [31:0] wait_ticks(logic [15:0] limit);
      logic [63:0] prod;
      logic [63:0] span;
      if (sb.freq_hz == 20'd0) begin
         return 32'd0;
      end
      prod = {48'd0, limit} * {44'd0, sb.freq_hz};
      span = (prod + 64'd999) / 64'd1000;
      return span[31:0];
   endfunction

   function automatic pps_req_type start_item(logic [3:0] solver, logic [4:0] count, bit ok);
      pps_req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom});
      r.route_id      = $urandom;
      r.tick_stamp    = $urandom;
      r.func          = FUNC_START;
      r.solver_result = solver;
      r.plan_moves    = count;
      r.submit_ok     = ok;
      return r;
   endfunction

   function automatic pps_req_type random_start();
      logic [3:0] solver;
      logic [4:0] count;
      int         roll;
      solver = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : SOLVER_OK;
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         count = 5'd0;
      end else if (roll == 1) begin
         count = MOVE_CAP;
      end else if (roll == 2) begin
         count = 5'($urandom_range(17, 31));
      end else if (roll < 5) begin
         count = 5'($urandom_range(4, 15));
      end else begin
         count = 5'($urandom_range(1, 3));
      end
      return start_item(solver, count, $urandom_range(0, 19) != 0);
   endfunction

   function automatic pps_req_type noise_item();
      pps_req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom});
      r.tick_stamp = $urandom;
      r.route_id   = $urandom;
      r.func       = 1'($urandom);
      return r;
   endfunction

   // Poll item shaped on the predicted phase. tick_mode 0 lands one tick
   // short of the timed limit, 1 right on it, 2 anywhere around it. With
   // push set the route report moves the phase on; noisy adds stray ids,
   // route errors and crane refusals.
   function automatic pps_req_type guided_poll(int tick_mode, bit push, bit noisy);
      pps_req_type r;
      logic [15:0] limit;
      logic [31:0] need;
      bit          timed;
      int          roll;
      r = REQ_W'({$urandom, $urandom, $urandom});
      r.func          = FUNC_POLL;
      r.submit_ok     = !noisy || ($urandom_range(0, 19) != 0);
      r.crane_ok      = !noisy || ($urandom_range(0, 24) != 0);
      r.route_id      = sb.plan_id;
      r.route_result  = ROUTE_OK;
      if (noisy && $urandom_range(0, 39) == 0) begin
         r.route_id = $urandom;
      end
      if (noisy && $urandom_range(0, 49) == 0) begin
         r.route_result = 4'($urandom_range(1, 15));
      end
      r.tick_stamp = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
                     sb.mark_tick + 32'($urandom_range(0, 2000));
      if (push) begin
         case (sb.phase)
            ST_WAIT_ROUTE: r.route_active = 1'b1;
            ST_APPROACH: begin
               r.route_phase    = PHASE_APPROACH;
               r.route_complete = 1'b1;
            end
            ST_TRANSFER: begin
               r.route_phase    = PHASE_TRANSFER;
               r.route_complete = 1'b1;
               r.route_active   = 1'b0;
            end
            default: ;
         endcase
      end
      timed = 1'b1;
      case (sb.phase)
         ST_LOWER_PICK, ST_RAISE_PICK, ST_LOWER_PLACE, ST_RAISE_PLACE: limit = sb.lift_ms;
         ST_GRIP_DWELL:    limit = sb.grip_ms;
         ST_RELEASE_DWELL: limit = sb.release_ms;
         default: begin
            limit = '0;
            timed = 1'b0;
         end
      endcase
      if (timed) begin
         need = wait_ticks(limit);
         roll = (tick_mode == 2) ? $urandom_range(0, 9) : tick_mode;
         if (roll == 0 || roll == 2) begin
            r.tick_stamp = sb.mark_tick + ((need == 0) ? 32'd0 : need - 32'd1);
         end else if (roll == 1 || roll < 7) begin
            r.tick_stamp = sb.mark_tick + need;
         end else if (roll < 9) begin
            r.tick_stamp = sb.mark_tick + need + 32'($urandom_range(0, 5000));
         end else begin
            r.tick_stamp = $urandom;
         end
      end
      return r;
   endfunction

   // Offer one item and wait until the block takes it.
   task automatic send_item(pps_req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func           <= r.func;
      req_solver_result  <= r.solver_result;
      req_plan_moves     <= r.plan_moves;
      req_submit_ok      <= r.submit_ok;
      req_tick_stamp     <= r.tick_stamp;
      req_route_id       <= r.route_id;
      req_route_result   <= r.route_result;
      req_route_active   <= r.route_active;
      req_route_phase    <= r.route_phase;
      req_route_complete <= r.route_complete;
      req_crane_ok       <= r.crane_ok;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (!(req_valid && !req_stall)) begin
         @(posedge clock);
      end
      sb.note_item(r);
      @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      sb.load_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Hold the sender until every predicted status item has come back.
   task automatic drain_status();
      req_valid <= 1'b0;
      while (sb.status_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Receiver stalls in runs of random length.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = $urandom_range(1, 20);
         rsp_stall <= 1'b0;
         repeat (run) @(negedge clock);
         run = pick_gap();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
         end
      end
   end

   // Compare every status item the block hands over.
   always @(posedge clock) begin
      pps_rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.exec_state        = rsp_exec_state;
         got.decision_result   = rsp_decision_result;
         got.last_route_result = rsp_last_route_result;
         got.active_move       = rsp_active_move;
         got.active_plan_id    = rsp_active_plan_id;
         got.cmd_submit        = rsp_cmd_submit;
         got.cmd_cancel        = rsp_cmd_cancel;
         got.cmd_grip          = rsp_cmd_grip;
         got.cmd_raise         = rsp_cmd_raise;
         got.cmd_resume        = rsp_cmd_resume;
         got.published         = rsp_published;
         sb.check_status(got);
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus: directed plans, then random segments under changing settings.
   initial begin
      pps_req_type r;
      logic [3:0]  last_phase;
      int          dwell_cnt;
      int          roll;
      int          n;
      int          k;
      sb = new();
      calm = 1'b0;
      idle_cycles = 0;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_POLL;
      req_solver_result = '0;
      req_plan_moves = '0;
      req_submit_ok = 1'b0;
      req_tick_stamp = '0;
      req_route_id = '0;
      req_route_result = '0;
      req_route_active = 1'b0;
      req_route_phase = 1'b0;
      req_route_complete = 1'b0;
      req_crane_ok = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Failed solver, empty plan, oversize plan with a refused submission,
      // and a poll while nothing runs.
      send_item(start_item(4'd9, 5'd2, 1'b1));
      send_item(start_item(SOLVER_OK, 5'd0, 1'b1));
      send_item(start_item(SOLVER_OK, 5'd31, 1'b0));
      send_item(guided_poll(2, 1'b1, 1'b0));

      // Good start whose first route report carries the no-code value.
      send_item(start_item(SOLVER_OK, 5'd2, 1'b1));
      r = guided_poll(1, 1'b1, 1'b0);
      r.route_result = ROUTE_NO_CODE;
      send_item(r);

      // One-move plan walked through every phase; each timed wait is
      // probed one tick short of its limit first. A report on a stale plan
      // id comes before.
      send_item(start_item(SOLVER_OK, 5'd1, 1'b1));
      r = guided_poll(1, 1'b1, 1'b0);
      r.route_id = sb.plan_id + 32'd1;
      send_item(r);
      for (k = 0; k < 10 && sb.running; k++) begin
         last_phase = sb.phase;
         send_item(guided_poll(0, 1'b1, 1'b0));
         if (sb.running && sb.phase == last_phase) begin
            send_item(guided_poll(1, 1'b1, 1'b0));
         end
      end

      last_phase = sb.phase;
      dwell_cnt = 0;
      for (int seg = 0; seg < 6; seg++) begin
         // Registers change only once every status item is back.
         drain_status();
         calm = (seg == 3);
         case (seg)
            0: begin
               csr_write(REG_LIFT_TRAVEL, 32'd0);
               csr_write(REG_GRIP_DWELL, 32'd0);
               csr_write(REG_RELEASE_DWELL, 32'd0);
               csr_write(REG_TICK_FREQ, 32'd1000000);
            end
            1: begin
               csr_write(REG_LIFT_TRAVEL, 32'd65535);
               csr_write(REG_GRIP_DWELL, 32'd65535);
               csr_write(REG_RELEASE_DWELL, 32'd65535);
               csr_write(REG_TICK_FREQ, 32'hFFFFF);
            end
            2: begin
               csr_write(REG_LIFT_TRAVEL, 32'd350);
               csr_write(REG_GRIP_DWELL, 32'd300);
               csr_write(REG_RELEASE_DWELL, 32'd200);
               csr_write(REG_TICK_FREQ, 32'd1000);
            end
            3: begin
               // Zero tick rate with zero limits: every timed wait passes.
               csr_write(REG_LIFT_TRAVEL, 32'd0);
               csr_write(REG_GRIP_DWELL, 32'd0);
               csr_write(REG_RELEASE_DWELL, 32'd0);
               csr_write(REG_TICK_FREQ, 32'd0);
            end
            4: begin
               // Zero tick rate with a nonzero dwell: the grip dwell never ends.
               csr_write(REG_GRIP_DWELL, 32'd7);
            end
            default: begin
               // Random settings; upper data bits are don't-care.
               csr_write(REG_LIFT_TRAVEL, {16'($urandom), 16'($urandom_range(0, 500))});
               csr_write(REG_GRIP_DWELL, {16'($urandom), 16'($urandom_range(0, 500))});
               csr_write(REG_RELEASE_DWELL, {16'($urandom), 16'($urandom_range(0, 500))});
               csr_write(REG_TICK_FREQ, {12'($urandom), 20'($urandom_range(1, 1000000))});
            end
         endcase

         for (n = 0; n < SEG_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if ((!sb.running && roll < 80) || dwell_cnt > 14 || roll < 2) begin
               r = random_start();
            end else if (roll < 12) begin
               r = noise_item();
            end else begin
               r = guided_poll(2, $urandom_range(0, 9) < 7, 1'b1);
            end
            send_item(r);
            if (sb.phase == last_phase) begin
               dwell_cnt++;
            end else begin
               dwell_cnt = 0;
            end
            last_phase = sb.phase;
         end
      end

      // Drain and let the pipeline settle before the verdict.
      req_valid <= 1'b0;
      while (sb.status_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.status_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/pps_pkg.sv
src/pps_core.sv
src/pick_place_sequencer.sv
src/pps_checker.sv
tb/sv/pick_place_sequencer_tb.sv
